/* src/lec_pkg.sv */
// ----------------------------------------------------------------------------
// lec_pkg: shared definitions for the LMS echo canceller
// Widths, defaults, sequencer states and the pipeline tag that travels with
// each tap through the shared multiplier and the weight update stages.
// ----------------------------------------------------------------------------
package lec_pkg;

  // Default configuration.
  localparam int unsigned TapsDef       = 160;
  localparam int unsigned WeightFracDef = 40;

  // Fixed field widths.
  localparam int unsigned SampleW = 16;
  localparam int unsigned WeightW = 48;
  localparam int unsigned ShiftW  = 6;
  localparam logic [ShiftW-1:0] ShiftReset = 6'd38;

  // The 48-bit weight is split in two halves for the multiplier.
  localparam int unsigned WeightSplit = 24;
  localparam int unsigned MulAW       = WeightSplit + 1;
  localparam int unsigned MulPW       = MulAW + SampleW;

  // Error is a 17-bit integer, error times sample fits in 33 bits.
  localparam int unsigned ErrW   = SampleW + 1;
  localparam int unsigned ProdW  = ErrW + SampleW;
  // Update deltas are clamped to +-2^49, so 51 signed bits hold them.
  localparam int unsigned DeltaW = 51;

  // Tap index width large enough for the largest supported tap count.
  localparam int unsigned TagIdxW = 10;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MAC,
    S_COMB,
    S_ROUND,
    S_ERR,
    S_UPD,
    S_OUT
  } lec_state_e;

  typedef struct packed {
    logic               valid;
    logic               last;
    logic [TagIdxW-1:0] idx;
  } lec_tag_t;

endpackage

/* src/lms_echo_canceller_top.sv */
// Operation: an accepted item gets one multiply pass and one weight update pass
//   over the taps before its result is loaded into the output register.
// Items: no new item is accepted before the last result is loaded, set by the
//   single shared multiplier pair and the one read port of each tap memory.
// Reset: a clearing pass over every tap zeroes both tap memories; no item is
//   accepted during it. Step shift resets to 38.
// ----------------------------------------------------------------------------
// lms_echo_canceller_top: LMS adaptive FIR echo canceller
// Delay line and weights live in memories. A small sequencer runs a MAC pass
// to form the echo estimate, then an update pass that adapts every weight.
// ----------------------------------------------------------------------------
module lms_echo_canceller_top import lec_pkg::*; #(
  parameter int unsigned TAPS             = TapsDef,
  parameter int unsigned WEIGHT_FRAC_BITS = WeightFracDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [ShiftW-1:0]         cfg_step_shift_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic signed [SampleW-1:0] far_sample_i,
  input  logic signed [SampleW-1:0] near_sample_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [SampleW-1:0] error_sample_o
);

  localparam int unsigned IdxW = $clog2(TAPS);
  localparam int unsigned LoW  = MulPW + IdxW;
  localparam int unsigned AccW = LoW + WeightSplit;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TAPS - 1);

  lec_state_e state_q, state_d;

  logic [ShiftW-1:0]         step_shift_q;
  logic [IdxW-1:0]           head_q, head_d;
  logic [IdxW-1:0]           tap_idx_q;
  logic [IdxW-1:0]           dl_ptr_q;
  logic [IdxW-1:0]           pass_ptr;
  logic                      issue_en_q;
  logic                      start_pass;
  logic                      out_load;
  logic                      accept;

  logic signed [SampleW-1:0] near_q;
  logic signed [SampleW-1:0] dl_rd_q;
  logic [WeightW-1:0]        w_rd_q;
  logic [WeightW-1:0]        w_p_q;

  logic signed [MulAW-1:0]   mul_a_lo;
  logic signed [MulAW-1:0]   mul_a_hi;
  logic signed [MulPW-1:0]   pa_q;
  logic signed [MulPW-1:0]   pb_q;

  logic signed [LoW-1:0]     acc_lo_q;
  logic signed [LoW-1:0]     acc_hi_q;
  logic signed [AccW-1:0]    acc_q;
  logic signed [AccW-1:0]    round_bias;
  logic signed [AccW-1:0]    q_q;
  logic [SampleW-1:0]        est;
  logic signed [ErrW-1:0]    err_q;
  logic [SampleW-1:0]        err_sat;

  lec_tag_t                  t0, t1_q, t2_q, upd_tag_in, upd_tag_out;
  logic [WeightW-1:0]        upd_weight;

  logic                      dl_we;
  logic [IdxW-1:0]           dl_waddr;
  logic [SampleW-1:0]        dl_wdata;
  logic                      w_we;
  logic [IdxW-1:0]           w_waddr;
  logic [WeightW-1:0]        w_wdata;

  logic [SampleW-1:0]        dl_mem [TAPS];
  logic [WeightW-1:0]        w_mem  [TAPS];

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);
  assign accept      = in_valid_i && (state_q == S_IDLE);
  assign head_d      = (head_q == '0) ? LastIdx : head_q - IdxW'(1);

  // Sequencer: next state and pass strobes.
  always_comb begin
    state_d    = state_q;
    start_pass = 1'b0;
    pass_ptr   = head_q;
    out_load   = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        if (tap_idx_q == LastIdx) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          start_pass = 1'b1;
          pass_ptr   = head_d;
          state_d    = S_MAC;
        end
      end
      S_MAC: begin
        if (t2_q.valid && t2_q.last) state_d = S_COMB;
      end
      S_COMB:  state_d = S_ROUND;
      S_ROUND: state_d = S_ERR;
      S_ERR: begin
        start_pass = 1'b1;
        state_d    = S_UPD;
      end
      S_UPD: begin
        if (upd_tag_out.valid && upd_tag_out.last) state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_o || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_shift_q <= ShiftReset;
    end else if (cfg_valid_i) begin
      step_shift_q <= cfg_step_shift_i;
    end
  end

  // Tap counter, delay line pointer and head of the circular delay line.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_idx_q  <= '0;
      dl_ptr_q   <= '0;
      head_q     <= '0;
      issue_en_q <= 1'b0;
    end else begin
      if (accept) head_q <= head_d;
      if (state_q == S_CLEAR) begin
        if (tap_idx_q != LastIdx) tap_idx_q <= tap_idx_q + IdxW'(1);
      end else if (start_pass) begin
        tap_idx_q  <= '0;
        dl_ptr_q   <= pass_ptr;
        issue_en_q <= 1'b1;
      end else if (issue_en_q) begin
        tap_idx_q <= tap_idx_q + IdxW'(1);
        dl_ptr_q  <= (dl_ptr_q == LastIdx) ? '0 : dl_ptr_q + IdxW'(1);
        if (tap_idx_q == LastIdx) issue_en_q <= 1'b0;
      end
    end
  end

  // Tag pipeline alongside the memory read and multiply stages.
  always_comb begin
    t0.valid = issue_en_q;
    t0.last  = (tap_idx_q == LastIdx);
    t0.idx   = TagIdxW'(tap_idx_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t1_q <= '0;
      t2_q <= '0;
    end else begin
      t1_q <= t0;
      t2_q <= t1_q;
    end
  end

  // Memory write selection: clearing pass, new far sample, updated weight.
  always_comb begin
    dl_we    = (state_q == S_CLEAR) || accept;
    dl_waddr = (state_q == S_CLEAR) ? tap_idx_q : head_d;
    dl_wdata = (state_q == S_CLEAR) ? '0 : far_sample_i;
    w_we     = (state_q == S_CLEAR) || upd_tag_out.valid;
    w_waddr  = (state_q == S_CLEAR) ? tap_idx_q : upd_tag_out.idx[IdxW-1:0];
    w_wdata  = (state_q == S_CLEAR) ? '0 : upd_weight;
  end

  // Delay line memory.
  always_ff @(posedge clk_i) begin
    if (dl_we) dl_mem[dl_waddr] <= dl_wdata;
    dl_rd_q <= dl_mem[dl_ptr_q];
  end

  // Weight memory.
  always_ff @(posedge clk_i) begin
    if (w_we) w_mem[w_waddr] <= w_wdata;
    w_rd_q <= w_mem[tap_idx_q];
  end

  // Shared multiplier pair: weight halves in the MAC pass, error in the update.
  always_comb begin
    if (state_q == S_UPD) begin
      mul_a_lo = MulAW'(err_q);
      mul_a_hi = MulAW'(err_q);
    end else begin
      mul_a_lo = $signed({1'b0, w_rd_q[WeightSplit-1:0]});
      mul_a_hi = MulAW'($signed(w_rd_q[WeightW-1:WeightSplit]));
    end
  end

  always_ff @(posedge clk_i) begin
    pa_q  <= mul_a_lo * dl_rd_q;
    pb_q  <= mul_a_hi * dl_rd_q;
    w_p_q <= w_rd_q;
  end

  // Split accumulators for the two weight halves.
  always_ff @(posedge clk_i) begin
    if (start_pass) begin
      acc_lo_q <= '0;
      acc_hi_q <= '0;
    end else if (state_q == S_MAC && t2_q.valid) begin
      acc_lo_q <= acc_lo_q + LoW'(pa_q);
      acc_hi_q <= acc_hi_q + LoW'(pb_q);
    end
  end

  // Combine halves, truncate toward zero, then saturate and form the error.
  assign round_bias = acc_q[AccW-1] ? ((AccW'(1) << WEIGHT_FRAC_BITS) - AccW'(1)) : '0;

  always_comb begin
    if ((&q_q[AccW-1:SampleW-1]) || !(|q_q[AccW-1:SampleW-1])) begin
      est = q_q[SampleW-1:0];
    end else if (q_q[AccW-1]) begin
      est = {1'b1, {(SampleW-1){1'b0}}};
    end else begin
      est = {1'b0, {(SampleW-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) near_q <= near_sample_i;
    if (state_q == S_COMB) begin
      acc_q <= (AccW'(acc_hi_q) <<< WeightSplit) + AccW'(acc_lo_q);
    end
    if (state_q == S_ROUND) q_q <= (acc_q + round_bias) >>> WEIGHT_FRAC_BITS;
    if (state_q == S_ERR) err_q <= ErrW'(near_q) - ErrW'($signed(est));
  end

  // Weight update stages.
  always_comb begin
    upd_tag_in       = t2_q;
    upd_tag_in.valid = t2_q.valid && (state_q == S_UPD);
  end

  lec_wupd #(
    .WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS)
  ) u_wupd (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_shift_i (step_shift_q),
    .prod_i       (pa_q[ProdW-1:0]),
    .weight_i     (w_p_q),
    .tag_i        (upd_tag_in),
    .weight_o     (upd_weight),
    .tag_o        (upd_tag_out)
  );

  // Output register, saturated error.
  always_comb begin
    if (err_q[ErrW-1] == err_q[ErrW-2]) begin
      err_sat = err_q[SampleW-1:0];
    end else if (err_q[ErrW-1]) begin
      err_sat = {1'b1, {(SampleW-1){1'b0}}};
    end else begin
      err_sat = {1'b0, {(SampleW-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (out_load) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) error_sample_o <= err_sat;
  end

endmodule

/* src/lec_wupd.sv */
// ----------------------------------------------------------------------------
// lec_wupd: weight update stages
// Turns one error-times-sample product into a scaled delta (left shift with
// clamp, or flooring right shift), then adds it to the weight with 48-bit
// saturation. Two register stages; the tag rides along.
// ----------------------------------------------------------------------------
module lec_wupd import lec_pkg::*; #(
  parameter int unsigned WEIGHT_FRAC_BITS = WeightFracDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [ShiftW-1:0]        step_shift_i,
  input  logic signed [ProdW-1:0]  prod_i,
  input  logic [WeightW-1:0]       weight_i,
  input  lec_tag_t                 tag_i,
  output logic [WeightW-1:0]       weight_o,
  output lec_tag_t                 tag_o
);

  localparam logic [DeltaW-2:0] DeltaClamp = (DeltaW-1)'(1) << (DeltaW - 2);
  localparam logic [6:0]        FracAmt    = 7'(WEIGHT_FRAC_BITS);

  logic [6:0]               sh_ext;
  logic                     shift_left;
  logic [6:0]               lsh_amt;
  logic [6:0]               rsh_amt;
  logic                     prod_neg;
  logic [ProdW-1:0]         prod_mag;
  logic [DeltaW-2:0]        mag_ext;
  logic [DeltaW-2:0]        mag_lim;
  logic [DeltaW-2:0]        mag_scaled;
  logic signed [DeltaW-1:0] delta_left;
  logic signed [DeltaW-1:0] delta_right;

  logic signed [DeltaW-1:0] delta_q;
  logic [WeightW-1:0]       weight_q;
  lec_tag_t                 tag_mid_q;

  logic signed [DeltaW:0]   sum;
  logic [WeightW-1:0]       weight_sat;

  // Stage one: scale the product by 2^(frac - shift).
  always_comb begin
    sh_ext     = {1'b0, step_shift_i};
    shift_left = (sh_ext <= FracAmt);
    lsh_amt    = FracAmt - sh_ext;
    rsh_amt    = sh_ext - FracAmt;
    prod_neg   = prod_i[ProdW-1];
    prod_mag   = prod_neg ? (ProdW)'(-prod_i) : prod_i;
    mag_ext    = (DeltaW-1)'(prod_mag);
    mag_lim    = DeltaClamp >> lsh_amt;
    mag_scaled = (mag_ext > mag_lim) ? DeltaClamp : (mag_ext << lsh_amt);
    delta_left = prod_neg ? -$signed({1'b0, mag_scaled}) : $signed({1'b0, mag_scaled});
    // Arithmetic shift floors toward minus infinity.
    delta_right = $signed(DeltaW'(prod_i)) >>> rsh_amt;
  end

  always_ff @(posedge clk_i) begin
    delta_q  <= shift_left ? delta_left : delta_right;
    weight_q <= weight_i;
  end

  // Stage two: saturating add into the 48-bit weight.
  always_comb begin
    sum = $signed({{(DeltaW + 1 - WeightW){weight_q[WeightW-1]}}, weight_q})
        + $signed({delta_q[DeltaW-1], delta_q});
    if ((&sum[DeltaW:WeightW-1]) || !(|sum[DeltaW:WeightW-1])) begin
      weight_sat = sum[WeightW-1:0];
    end else if (sum[DeltaW]) begin
      weight_sat = {1'b1, {(WeightW-1){1'b0}}};
    end else begin
      weight_sat = {1'b0, {(WeightW-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    weight_o <= weight_sat;
  end

  // Tag pipeline.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_mid_q <= '0;
      tag_o     <= '0;
    end else begin
      tag_mid_q <= tag_i;
      tag_o     <= tag_mid_q;
    end
  end

endmodule

/* src/lec_checker.sv */
// ----------------------------------------------------------------------------
// lec_checker: port-level checks for the echo canceller
// Watches the handshakes of the top level and flags sequencing slips.
// ----------------------------------------------------------------------------
module lec_checker import lec_pkg::*; (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_stall_o,
  input logic                      out_valid_o,
  input logic                      out_stall_i,
  input logic signed [SampleW-1:0] error_sample_o
);

  // After an item is taken the input must stay stalled; only the start of the busy time is checked.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (in_stall_o ##1 in_stall_o))
    else $error("input taken again too soon after an item");

  // A new result only shows up as the block turns idle again.
  a_result_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !in_stall_o)
    else $error("result appeared while the block was still busy");

  // A stalled result stays valid.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("stalled result dropped");

  // A stalled result keeps its value.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(error_sample_o))
    else $error("stalled result changed");

endmodule

bind lms_echo_canceller_top lec_checker u_lec_checker (.*);
